// File: design/lpht_pkg.sv
// lpht_pkg: shared types and constants for the linear probe hash table
// depends on nothing; imported by every module of the block
package lpht_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 11;
  localparam int CNT_W   = 11;

  // bucket status codes
  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  // operation codes
  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_REPLACE = 2'd1;
  localparam logic [1:0] OP_DELETE  = 2'd2;
  localparam logic [1:0] OP_LOOKUP  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1021;

  typedef logic [1:0]       op_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

// File: design/linear_probe_hash_table.sv
// Linear probe hash table: key/data store with open addressing and tombstones.
// Each item passes through the acceptance, the home bucket (a start, 32
// bit-serial steps of key modulo size in lpht_mod_unit and a done), a read and
// a check of each bucket probed through the registered read port of the bucket
// memories, and a write back that loads the result; a result not yet taken by
// out_tready holds the block in that write back. A new item is taken only once
// the last result is loaded. After reset a clearing pass marks every bucket
// unused; no transaction is taken meanwhile. Depends on lpht_pkg.
module linear_probe_hash_table import lpht_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  // configuration: table_size
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  // input channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // key[31:0], value_in[63:32]
  input  logic [1:0]       in_tuser,   // operation[1:0]
  // result channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [55:0]      out_tdata,  // prev_value[31:0], entry_count[42:32],
                                       // tombstone_count[53:43], zero pad
  output logic [1:0]       out_tuser   // status[1:0]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  // bucket memories
  logic [1:0] status_mem [TABLE_DEPTH];
  key_t       key_mem    [TABLE_DEPTH];
  val_t       val_mem    [TABLE_DEPTH];

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] size_cfg_r;
  logic [SW-1:0]    eff_size;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  op_t              op_r, op_nxt;
  key_t             key_r, key_nxt;
  val_t             vin_r, vin_nxt;
  logic [AW-1:0]    pos_r, pos_nxt;
  logic [SW-1:0]    steps_r, steps_nxt;
  logic             found_r, found_nxt;
  logic             have_del_r, have_del_nxt;
  logic             have_free_r, have_free_nxt;
  logic [AW-1:0]    match_r, match_nxt;
  logic [AW-1:0]    del_r, del_nxt;
  logic [AW-1:0]    free_r, free_nxt;
  val_t             old_r, old_nxt;
  logic [SW-1:0]    live_r, live_nxt;
  logic [SW-1:0]    tomb_r, tomb_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  val_t             out_old_r, out_old_nxt;
  logic [CNT_W-1:0] out_live_r, out_live_nxt;
  logic [CNT_W-1:0] out_tomb_r, out_tomb_nxt;

  logic [1:0]    rd_status_q;
  key_t          rd_key_q;
  val_t          rd_val_q;

  logic          st_we, kv_we, val_we;
  logic [AW-1:0] wr_addr;
  logic [1:0]    st_wdata;

  logic          mod_go_r;
  logic          mod_start, mod_done;
  logic [SW-1:0] mod_rem;
  logic          out_free;
  logic [SW-1:0] pos_inc;
  logic [AW-1:0] new_slot;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_cfg_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_cfg_r <= cfg_wr_data;
    end
  end

  // size limited to 2..TABLE_DEPTH
  always_comb begin
    if (32'(size_cfg_r) < 32'd2) begin
      eff_size = SW'(2);
    end else if (32'(size_cfg_r) > 32'(TABLE_DEPTH)) begin
      eff_size = SW'(TABLE_DEPTH);
    end else begin
      eff_size = SW'(size_cfg_r);
    end
  end

  lpht_mod_unit #(.W(SW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (key_r),
    .divisor   (eff_size),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign out_free = !out_valid_r || out_tready;
  assign pos_inc  = SW'(pos_r) + 1'b1;
  assign new_slot = have_del_r ? del_r : free_r;

  // probe sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    vin_nxt        = vin_r;
    pos_nxt        = pos_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    have_del_nxt   = have_del_r;
    have_free_nxt  = have_free_r;
    match_nxt      = match_r;
    del_nxt        = del_r;
    free_nxt       = free_r;
    old_nxt        = old_r;
    live_nxt       = live_r;
    tomb_nxt       = tomb_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_old_nxt    = out_old_r;
    out_live_nxt   = out_live_r;
    out_tomb_nxt   = out_tomb_r;
    mod_start      = 1'b0;
    st_we          = 1'b0;
    kv_we          = 1'b0;
    val_we         = 1'b0;
    wr_addr        = pos_r;
    st_wdata       = SLOT_EMPTY;
    in_tready      = (state_r == S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        st_we        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt        = in_tuser;
          key_nxt       = in_tdata[31:0];
          vin_nxt       = in_tdata[63:32];
          found_nxt     = 1'b0;
          have_del_nxt  = 1'b0;
          have_free_nxt = 1'b0;
          old_nxt       = '0;
          steps_nxt     = '0;
          state_nxt     = S_MOD;
        end
      end
      S_MOD: begin
        // kick the modulo unit on the first cycle, once the key is held
        mod_start = mod_go_r;
        if (mod_done) begin
          pos_nxt   = AW'(mod_rem);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_READ;
        if (rd_status_q == SLOT_LIVE && rd_key_q == key_r) begin
          found_nxt = 1'b1;
          match_nxt = pos_r;
          old_nxt   = rd_val_q;
          state_nxt = S_FINISH;
        end else if (rd_status_q == SLOT_LIVE || rd_status_q == SLOT_TOMB) begin
          if (rd_status_q == SLOT_TOMB && !have_del_r) begin
            have_del_nxt = 1'b1;
            del_nxt      = pos_r;
          end
          steps_nxt = steps_r + 1'b1;
          pos_nxt   = (pos_inc == eff_size) ? '0 : AW'(pos_inc);
          if (steps_r + 1'b1 == eff_size) begin
            state_nxt = S_FINISH;
          end
        end else begin
          have_free_nxt = 1'b1;
          free_nxt      = pos_r;
          state_nxt     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_old_nxt = '0;
          if (found_r) begin
            out_old_nxt = old_r;
            wr_addr     = match_r;
            case (op_r)
              OP_INSERT: out_status_nxt = ST_PRESENT;
              OP_REPLACE: begin
                val_we         = 1'b1;
                out_status_nxt = ST_PRESENT;
              end
              OP_DELETE: begin
                st_we          = 1'b1;
                st_wdata       = SLOT_TOMB;
                live_nxt       = live_r - 1'b1;
                tomb_nxt       = tomb_r + 1'b1;
                out_status_nxt = ST_DONE;
              end
              default: out_status_nxt = ST_DONE;
            endcase
          end else if (!have_free_r && !have_del_r) begin
            out_status_nxt = ST_FULL;
          end else if (op_r == OP_INSERT || op_r == OP_REPLACE) begin
            wr_addr        = new_slot;
            st_we          = 1'b1;
            kv_we          = 1'b1;
            val_we         = 1'b1;
            st_wdata       = SLOT_LIVE;
            live_nxt       = live_r + 1'b1;
            if (have_del_r) begin
              tomb_nxt = tomb_r - 1'b1;
            end
            out_status_nxt = ST_DONE;
          end else begin
            out_status_nxt = ST_MISSING;
          end
          out_live_nxt  = CNT_W'(live_nxt);
          out_tomb_nxt  = CNT_W'(tomb_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // start pulse for the modulo unit, the cycle after the transaction lands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_go_r <= 1'b0;
    end else begin
      mod_go_r <= (state_r == S_IDLE) && in_tvalid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      live_r      <= '0;
      tomb_r      <= '0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      have_del_r  <= 1'b0;
      have_free_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      live_r      <= live_nxt;
      tomb_r      <= tomb_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      have_del_r  <= have_del_nxt;
      have_free_r <= have_free_nxt;
      steps_r     <= steps_nxt;
    end
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    vin_r        <= vin_nxt;
    pos_r        <= pos_nxt;
    match_r      <= match_nxt;
    del_r        <= del_nxt;
    free_r       <= free_nxt;
    old_r        <= old_nxt;
    out_status_r <= out_status_nxt;
    out_old_r    <= out_old_nxt;
    out_live_r   <= out_live_nxt;
    out_tomb_r   <= out_tomb_nxt;
  end

  // bucket memories, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (st_we) begin
      status_mem[wr_addr] <= st_wdata;
    end
    rd_status_q <= status_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[wr_addr] <= key_r;
    end
    rd_key_q <= key_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_addr] <= vin_r;
    end
    rd_val_q <= val_mem[pos_r];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_tomb_r, out_live_r, out_old_r};

  // counts never exceed the store
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(live_r) + 32'(tomb_r)) <= 32'(TABLE_DEPTH))
    else $error("entry and tombstone counts exceed the table depth");

  // a bucket check always follows its read
  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK |-> $past(state_r) == S_READ)
    else $error("bucket check without a preceding read");

  // the probe never walks past the buckets in use
  a_probe_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> (steps_r < eff_size && SW'(pos_r) < eff_size))
    else $error("probe ran beyond the table size");

  // an accepted transaction starts the modulo unit
  a_accept_starts_mod: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_MOD && mod_start)
    else $error("accepted transaction did not start the home bucket");

endmodule

// File: design/lpht_mod_unit.sv
// lpht_mod_unit: bit-serial restoring remainder of the key by the table size
// depends on lpht_pkg
module lpht_mod_unit import lpht_pkg::*; #(
  parameter int W = 11
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  key_t         dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] remainder
);

  localparam int CW = $clog2(KEY_W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  key_t          q_r, q_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W:0]    shifted;

  // one quotient bit a cycle while busy: shift in a dividend bit, subtract if it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    shifted  = {rem_r, q_r[KEY_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      q_nxt = {q_r[KEY_W-2:0], 1'b0};
      if (shifted >= {1'b0, d_r}) begin
        rem_nxt = W'(shifted - {1'b0, d_r});
      end else begin
        rem_nxt = W'(shifted);
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(KEY_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
